>>> rtl/segment_segment_distance_defines.svh
// ----------------------------------------------------------------------------
// Segment distance assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_DISTANCE_DEFINES_SVH
`define SEGMENT_SEGMENT_DISTANCE_DEFINES_SVH

// Same-cycle implication
`define SSD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Segment distance package
// Shared constants for the segment-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int DIST_BITS       = 25;
   localparam int NUM_PTS         = 4;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

endpackage

>>> rtl/segment_segment_distance.sv
// ----------------------------------------------------------------------------
// Segment-to-segment distance
// Exact 2D distance and intersect test between two fixed-point segments.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel req_*: one word carries both segments (eight signed
//    coordinates). A word is taken on a rising edge with req_valid high and
//    req_stall low.
//  - Result channel rsp_*: one word per input word, in order: rsp_distance
//    (unsigned, same fraction as the inputs, rounded down) and rsp_intersects.
//  - Throughput is one word per cycle while the receiver does not stall; the
//    per-bit root search yields one result bit per pipeline stage.
//  - Stage walk: register inputs, differences, products, dot/cross sums,
//    intersect decision and operand select with split square, operand
//    assembly, DIST_BITS root stages, then the minimum of four candidates.
//  - When the receiver stalls, the result word holds and empty stages keep
//    filling; req_stall rises only once every stage holds a word.
//  - Reset empties the pipeline: all valid bits clear, no result is shown.
// ----------------------------------------------------------------------------
`include "segment_segment_distance_defines.svh"

module segment_segment_distance
   import ssd_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_x1,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_y1,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_x2,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_y2,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_x1,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_y1,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_x2,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_y2,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [DIST_BITS-1:0]          rsp_distance,
   output logic                          rsp_intersects
);

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;             // coordinate difference
   localparam int PW  = 2 * DW;            // product
   localparam int XW  = PW + 1;            // sum of two products
   localparam int NW  = 2 * PW;            // squared cross
   localparam int DB  = DIST_BITS;
   localparam int PPW = DB + PW;           // d * m
   localparam int EW  = PW + 2 * DB + 1;   // trial increment
   localparam int CW  = (EW > NW) ? EW : NW;
   localparam int H   = (PW + 1) / 2;      // low half of |cross|
   localparam int HW  = PW - H;            // high half of |cross|
   localparam int NS  = DB + 6;            // stages with a valid bit

   // Pipeline control: a stage may load when it is empty or its word moves on
   logic [NS-1:0] vld_ff;
   logic [NS:0]   en;
   logic          rsp_valid_ff;
   logic [DB-1:0] rsp_distance_ff;
   logic          rsp_intersects_ff;

   always_comb begin
      en[NS] = !rsp_valid_ff || !rsp_stall;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_stall      = !en[0];
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance   = rsp_distance_ff;
   assign rsp_intersects = rsp_intersects_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (en[NS]) begin
            rsp_valid_ff <= vld_ff[NS-1];
         end
      end
   end

   // Point order: a1, a2, b1, b2. Candidate j measures point j against the
   // other segment; segment 0 is A, segment 1 is B.
   function automatic logic in_box(
      input logic signed [W-1:0] s1x, input logic signed [W-1:0] s1y,
      input logic signed [W-1:0] s2x, input logic signed [W-1:0] s2y,
      input logic signed [W-1:0] px,  input logic signed [W-1:0] py
   );
      logic signed [W-1:0] lx, hx, ly, hy;
      lx = (s1x < s2x) ? s1x : s2x;
      hx = (s1x < s2x) ? s2x : s1x;
      ly = (s1y < s2y) ? s1y : s2y;
      hy = (s1y < s2y) ? s2y : s1y;
      return (px >= lx) && (px <= hx) && (py >= ly) && (py <= hy);
   endfunction

   // Stage 1: input word
   logic signed [W-1:0] pt_x_ff [NUM_PTS];
   logic signed [W-1:0] pt_y_ff [NUM_PTS];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pt_x_ff[0] <= req_seg_a_x1;
         pt_y_ff[0] <= req_seg_a_y1;
         pt_x_ff[1] <= req_seg_a_x2;
         pt_y_ff[1] <= req_seg_a_y2;
         pt_x_ff[2] <= req_seg_b_x1;
         pt_y_ff[2] <= req_seg_b_y1;
         pt_x_ff[3] <= req_seg_b_x2;
         pt_y_ff[3] <= req_seg_b_y2;
      end
   end

   // Stage 2: differences and bounding-box hits
   logic signed [DW-1:0] ux_ff  [2];
   logic signed [DW-1:0] uy_ff  [2];
   logic signed [DW-1:0] v1x_ff [NUM_PTS];
   logic signed [DW-1:0] v1y_ff [NUM_PTS];
   logic signed [DW-1:0] v2x_ff [NUM_PTS];
   logic signed [DW-1:0] v2y_ff [NUM_PTS];
   logic [NUM_PTS-1:0]   box2_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         ux_ff[0] <= DW'(pt_x_ff[1]) - DW'(pt_x_ff[0]);
         uy_ff[0] <= DW'(pt_y_ff[1]) - DW'(pt_y_ff[0]);
         ux_ff[1] <= DW'(pt_x_ff[3]) - DW'(pt_x_ff[2]);
         uy_ff[1] <= DW'(pt_y_ff[3]) - DW'(pt_y_ff[2]);
      end
   end

   // Stage 3 and 4 storage
   logic signed [PW-1:0] pla_ff [2];
   logic signed [PW-1:0] plb_ff [2];
   logic signed [PW-1:0] pd1a_ff [NUM_PTS];
   logic signed [PW-1:0] pd1b_ff [NUM_PTS];
   logic signed [PW-1:0] pd2a_ff [NUM_PTS];
   logic signed [PW-1:0] pd2b_ff [NUM_PTS];
   logic signed [PW-1:0] pca_ff  [NUM_PTS];
   logic signed [PW-1:0] pcb_ff  [NUM_PTS];
   logic signed [PW-1:0] pq1a_ff [NUM_PTS];
   logic signed [PW-1:0] pq1b_ff [NUM_PTS];
   logic signed [PW-1:0] pq2a_ff [NUM_PTS];
   logic signed [PW-1:0] pq2b_ff [NUM_PTS];
   logic [NUM_PTS-1:0]   box3_ff;

   logic [PW-1:0]        l2_ff   [2];
   logic signed [XW-1:0] dot1_ff [NUM_PTS];
   logic signed [XW-1:0] dot2_ff [NUM_PTS];
   logic signed [XW-1:0] crs_ff  [NUM_PTS];
   logic [PW-1:0]        q1_ff   [NUM_PTS];
   logic [PW-1:0]        q2_ff   [NUM_PTS];
   logic [NUM_PTS-1:0]   box4_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         box3_ff <= box2_ff;
         for (int s = 0; s < 2; s++) begin
            pla_ff[s] <= PW'(ux_ff[s]) * PW'(ux_ff[s]);
            plb_ff[s] <= PW'(uy_ff[s]) * PW'(uy_ff[s]);
         end
      end
      if (en[3]) begin
         box4_ff <= box3_ff;
         for (int s = 0; s < 2; s++) begin
            l2_ff[s] <= PW'(XW'(pla_ff[s]) + XW'(plb_ff[s]));
         end
      end
   end

   // Stage 5 and 6 storage
   logic                 meet5_ff;
   logic [NUM_PTS-1:0]   perp_ff;
   logic [NUM_PTS-1:0]   sat5_ff;
   logic [PW-1:0]        m5_ff   [NUM_PTS];
   logic [PW-1:0]        pq_ff   [NUM_PTS];
   logic [2*H-1:0]       pll_ff  [NUM_PTS];
   logic [H+HW-1:0]      plh_ff  [NUM_PTS];
   logic [2*HW-1:0]      phh_ff  [NUM_PTS];

   // Root search storage; index 0 is the assembled operand stage
   logic [NW-1:0]        rt_r_ff   [DB+1][NUM_PTS];
   logic [PPW-1:0]       rt_p_ff   [DB+1][NUM_PTS];
   logic [DB-1:0]        rt_d_ff   [DB+1][NUM_PTS];
   logic [PW-1:0]        rt_m_ff   [DB+1][NUM_PTS];
   logic [NUM_PTS-1:0]   rt_sat_ff [DB+1];
   logic                 rt_meet_ff[DB+1];

   // Intersect decision from orientation signs and box hits
   logic [NUM_PTS-1:0] crs_neg, crs_zero;
   logic               meet_in;

   always_comb begin
      for (int j = 0; j < NUM_PTS; j++) begin
         crs_neg[j]  = crs_ff[j][XW-1];
         crs_zero[j] = (crs_ff[j] == '0);
      end
      meet_in = (!crs_zero[0] && !crs_zero[1] && (crs_neg[0] != crs_neg[1]) &&
                 !crs_zero[2] && !crs_zero[3] && (crs_neg[2] != crs_neg[3])) ||
                ((crs_zero & box4_ff) != '0);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         meet5_ff <= meet_in;
      end
   end

   for (genvar j = 0; j < NUM_PTS; j++) begin : g_cand
      localparam int S1 = (j < 2) ? 2 : 0;
      localparam int S2 = (j < 2) ? 3 : 1;
      localparam int SG = (j < 2) ? 1 : 0;

      logic                 dir1, dir2, perp;
      logic signed [XW-1:0] c_abs;
      logic [PW-1:0]        c_mag;
      logic [H-1:0]         c_lo;
      logic [HW-1:0]        c_hi;
      logic [NW-1:0]        n_perp;

      always_ff @(posedge clock) begin
         if (en[1]) begin
            v1x_ff[j]  <= DW'(pt_x_ff[j]) - DW'(pt_x_ff[S1]);
            v1y_ff[j]  <= DW'(pt_y_ff[j]) - DW'(pt_y_ff[S1]);
            v2x_ff[j]  <= DW'(pt_x_ff[j]) - DW'(pt_x_ff[S2]);
            v2y_ff[j]  <= DW'(pt_y_ff[j]) - DW'(pt_y_ff[S2]);
            box2_ff[j] <= in_box(pt_x_ff[S1], pt_y_ff[S1], pt_x_ff[S2], pt_y_ff[S2],
                                 pt_x_ff[j], pt_y_ff[j]);
         end
         if (en[2]) begin
            pd1a_ff[j] <= PW'(v1x_ff[j]) * PW'(ux_ff[SG]);
            pd1b_ff[j] <= PW'(v1y_ff[j]) * PW'(uy_ff[SG]);
            pd2a_ff[j] <= PW'(v2x_ff[j]) * PW'(ux_ff[SG]);
            pd2b_ff[j] <= PW'(v2y_ff[j]) * PW'(uy_ff[SG]);
            pca_ff[j]  <= PW'(ux_ff[SG]) * PW'(v1y_ff[j]);
            pcb_ff[j]  <= PW'(uy_ff[SG]) * PW'(v1x_ff[j]);
            pq1a_ff[j] <= PW'(v1x_ff[j]) * PW'(v1x_ff[j]);
            pq1b_ff[j] <= PW'(v1y_ff[j]) * PW'(v1y_ff[j]);
            pq2a_ff[j] <= PW'(v2x_ff[j]) * PW'(v2x_ff[j]);
            pq2b_ff[j] <= PW'(v2y_ff[j]) * PW'(v2y_ff[j]);
         end
         if (en[3]) begin
            dot1_ff[j] <= XW'(pd1a_ff[j]) + XW'(pd1b_ff[j]);
            dot2_ff[j] <= XW'(pd2a_ff[j]) + XW'(pd2b_ff[j]);
            crs_ff[j]  <= XW'(pca_ff[j]) - XW'(pcb_ff[j]);
            q1_ff[j]   <= PW'(XW'(pq1a_ff[j]) + XW'(pq1b_ff[j]));
            q2_ff[j]   <= PW'(XW'(pq2a_ff[j]) + XW'(pq2b_ff[j]));
         end
      end

      // Zero length or projection before the start: distance to the start.
      // Projection past the end: distance to the end. Else perpendicular.
      always_comb begin
         dir1  = (l2_ff[SG] == '0) || dot1_ff[j][XW-1];
         dir2  = !dir1 && !dot2_ff[j][XW-1] && (dot2_ff[j] != '0);
         perp  = !dir1 && !dir2;
         c_abs = crs_ff[j][XW-1] ? -crs_ff[j] : crs_ff[j];
         c_mag = c_abs[PW-1:0];
         c_lo  = c_mag[H-1:0];
         c_hi  = c_mag[PW-1:H];
      end

      always_ff @(posedge clock) begin
         if (en[4]) begin
            perp_ff[j] <= perp;
            sat5_ff[j] <= perp && ((c_mag >> 64) != '0);
            m5_ff[j]   <= perp ? l2_ff[SG] : PW'(1);
            pq_ff[j]   <= dir2 ? q2_ff[j] : q1_ff[j];
            pll_ff[j]  <= (2*H)'(c_lo) * (2*H)'(c_lo);
            plh_ff[j]  <= (H+HW)'(c_lo) * (H+HW)'(c_hi);
            phh_ff[j]  <= (2*HW)'(c_hi) * (2*HW)'(c_hi);
         end
      end

      // Assemble the squared cross from its partial products
      assign n_perp = (NW'(phh_ff[j]) << (2*H)) + (NW'(plh_ff[j]) << (H+1)) +
                      NW'(pll_ff[j]);

      always_ff @(posedge clock) begin
         if (en[5]) begin
            rt_r_ff[0][j] <= perp_ff[j] ? n_perp : NW'(pq_ff[j]);
            rt_p_ff[0][j] <= '0;
            rt_d_ff[0][j] <= '0;
            rt_m_ff[0][j] <= m5_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         rt_sat_ff[0]  <= sat5_ff;
         rt_meet_ff[0] <= meet5_ff;
      end
   end

   // Root search: one result bit per stage, largest d with d*d*m <= n.
   // Keep R = n - d*d*m and P = d*m so each trial is a shift and add.
   for (genvar i = 1; i <= DB; i++) begin : g_root
      localparam int K = DB - i;

      always_ff @(posedge clock) begin
         if (en[5+i]) begin
            rt_sat_ff[i]  <= rt_sat_ff[i-1];
            rt_meet_ff[i] <= rt_meet_ff[i-1];
         end
      end

      for (genvar j = 0; j < NUM_PTS; j++) begin : g_lane
         logic [CW-1:0] inc;
         logic          fit;

         always_comb begin
            inc = (CW'(rt_p_ff[i-1][j]) << (K + 1)) + (CW'(rt_m_ff[i-1][j]) << (2 * K));
            fit = inc <= CW'(rt_r_ff[i-1][j]);
         end

         always_ff @(posedge clock) begin
            if (en[5+i]) begin
               rt_m_ff[i][j] <= rt_m_ff[i-1][j];
               rt_r_ff[i][j] <= fit ? rt_r_ff[i-1][j] - NW'(inc) : rt_r_ff[i-1][j];
               rt_p_ff[i][j] <= fit ? rt_p_ff[i-1][j] + (PPW'(rt_m_ff[i-1][j]) << K)
                                    : rt_p_ff[i-1][j];
               rt_d_ff[i][j] <= fit ? rt_d_ff[i-1][j] | (DB'(1) << K) : rt_d_ff[i-1][j];
            end
         end
      end
   end

   // Output: least of four candidates, zero on intersect
   logic [DB-1:0] cand_d [NUM_PTS];
   logic [DB-1:0] min_lo, min_hi, min_all;

   always_comb begin
      for (int j = 0; j < NUM_PTS; j++) begin
         cand_d[j] = rt_sat_ff[DB][j] ? DIST_MAX : rt_d_ff[DB][j];
      end
      min_lo  = (cand_d[1] < cand_d[0]) ? cand_d[1] : cand_d[0];
      min_hi  = (cand_d[3] < cand_d[2]) ? cand_d[3] : cand_d[2];
      min_all = (min_hi < min_lo) ? min_hi : min_lo;
   end

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         rsp_intersects_ff <= rt_meet_ff[DB];
         rsp_distance_ff   <= rt_meet_ff[DB] ? '0 : min_all;
      end
   end

   // Checks
   `SSD_ASSERT_IMPLY(a_hit_zero, clock, reset, rsp_valid_ff && rsp_intersects_ff, rsp_distance_ff == '0, "intersect with nonzero distance")
   `SSD_ASSERT_IMPLY(a_stall_full, clock, reset, req_stall, rsp_valid_ff && rsp_stall && (vld_ff == '1), "input stalled while pipeline has room")
   `SSD_ASSERT_NEXT(a_accept_enter, clock, reset, req_valid && !req_stall, vld_ff[0], "accepted word lost at first stage")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment-to-segment distance testbench
// Drives segment pairs through the valid/stall input channel, predicts the
// exact floor distance and intersect flag for each accepted word, and checks
// every result word in order under random sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench
   import ssd_pkg::*;
();

   localparam int CW = COORD_WIDTH_DEF;
   localparam int PIPE_DEPTH = DIST_BITS + 6;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      coord_type ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
   } seg_pair_type;

   typedef struct {
      logic [DIST_BITS-1:0] distance;
      logic                 meet;
   } gap_type;

   typedef struct {
      longint x, y;
   } pt_type;

   // Scoreboard: predict the gap between two segments, hold pending results
   class gap_scoreboard;
      gap_type pending[$];
      int      errors = 0;

      function automatic int sgn(longint v);
         return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
      endfunction

      // cross(s2 - s1, p - s1)
      function automatic longint cross3(pt_type s1, pt_type s2, pt_type p);
         return (s2.x - s1.x) * (p.y - s1.y) - (s2.y - s1.y) * (p.x - s1.x);
      endfunction

      // (p - s1) . (s2 - s1)
      function automatic longint dot(pt_type s1, pt_type s2, pt_type p);
         return (p.x - s1.x) * (s2.x - s1.x) + (p.y - s1.y) * (s2.y - s1.y);
      endfunction

      function automatic longint sq_len(pt_type a, pt_type b);
         return (b.x - a.x) * (b.x - a.x) + (b.y - a.y) * (b.y - a.y);
      endfunction

      // Largest d below 2^DIST_BITS with d*d*m <= n
      function automatic logic [DIST_BITS-1:0] root_floor(logic [127:0] m,
                                                           logic [127:0] n);
         logic [DIST_BITS-1:0] d;
         logic [DIST_BITS-1:0] t;
         logic [127:0]         p;
         d = '0;
         for (int b = DIST_BITS - 1; b >= 0; b--) begin
            t = d | (DIST_BITS'(1) << b);
            p = 128'(t) * 128'(t) * m;
            if (p <= n) d = t;
         end
         return d;
      endfunction

      function automatic logic [DIST_BITS-1:0] pt_gap(pt_type a, pt_type b);
         return root_floor(128'd1, 128'(sq_len(a, b)));
      endfunction

      function automatic logic [DIST_BITS-1:0] pt_seg_gap(pt_type p, pt_type s1,
                                                          pt_type s2);
         longint       l2;
         longint       c;
         logic [127:0] cm;
         l2 = sq_len(s1, s2);
         if (l2 == 0) return pt_gap(p, s1);
         if (dot(s1, s2, p) < 0) return pt_gap(p, s1);
         if (dot(s2, s1, p) < 0) return pt_gap(p, s2);
         c = cross3(s1, s2, p);
         if (c < 0) c = -c;
         cm = 128'(c);
         return root_floor(128'(l2), cm * cm);
      endfunction

      function automatic bit in_box(pt_type s1, pt_type s2, pt_type p);
         longint lx, hx, ly, hy;
         lx = (s1.x < s2.x) ? s1.x : s2.x;
         hx = (s1.x < s2.x) ? s2.x : s1.x;
         ly = (s1.y < s2.y) ? s1.y : s2.y;
         hy = (s1.y < s2.y) ? s2.y : s1.y;
         return p.x >= lx && p.x <= hx && p.y >= ly && p.y <= hy;
      endfunction

      function automatic bit touch(pt_type a1, pt_type a2, pt_type b1, pt_type b2);
         int d1, d2, d3, d4;
         d1 = sgn(cross3(b1, b2, a1));
         d2 = sgn(cross3(b1, b2, a2));
         d3 = sgn(cross3(a1, a2, b1));
         d4 = sgn(cross3(a1, a2, b2));
         if (d1 * d2 < 0 && d3 * d4 < 0) return 1;
         if (d1 == 0 && in_box(b1, b2, a1)) return 1;
         if (d2 == 0 && in_box(b1, b2, a2)) return 1;
         if (d3 == 0 && in_box(a1, a2, b1)) return 1;
         if (d4 == 0 && in_box(a1, a2, b2)) return 1;
         return 0;
      endfunction

      // Note an accepted pair and queue its expected gap
      function void note_pair(seg_pair_type s);
         pt_type               a1, a2, b1, b2;
         gap_type              g;
         logic [DIST_BITS-1:0] d;
         a1.x = longint'(s.ax1); a1.y = longint'(s.ay1);
         a2.x = longint'(s.ax2); a2.y = longint'(s.ay2);
         b1.x = longint'(s.bx1); b1.y = longint'(s.by1);
         b2.x = longint'(s.bx2); b2.y = longint'(s.by2);
         if (touch(a1, a2, b1, b2)) begin
            g.distance = '0;
            g.meet = 1'b1;
         end else begin
            g.meet = 1'b0;
            g.distance = pt_seg_gap(a1, b1, b2);
            d = pt_seg_gap(a2, b1, b2); if (d < g.distance) g.distance = d;
            d = pt_seg_gap(b1, a1, a2); if (d < g.distance) g.distance = d;
            d = pt_seg_gap(b2, a1, a2); if (d < g.distance) g.distance = d;
         end
         pending.push_back(g);
      endfunction

      // Check one result word against the oldest prediction
      function void check_gap(logic [DIST_BITS-1:0] distance, logic meet);
         gap_type g;
         if (pending.size() == 0) begin
            $error("result word with no prediction pending");
            errors++;
            return;
         end
         g = pending.pop_front();
         if (distance !== g.distance) begin
            $error("distance: expected %0d, actual %0d", g.distance, distance);
            errors++;
         end
         if (meet !== g.meet) begin
            $error("intersects: expected %0d, actual %0d", g.meet, meet);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   coord_type            req_seg_a_x1 = '0, req_seg_a_y1 = '0;
   coord_type            req_seg_a_x2 = '0, req_seg_a_y2 = '0;
   coord_type            req_seg_b_x1 = '0, req_seg_b_y1 = '0;
   coord_type            req_seg_b_x2 = '0, req_seg_b_y2 = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DIST_BITS-1:0] rsp_distance;
   logic                 rsp_intersects;

   gap_scoreboard sb = new();
   int            send_idle_pct = 0;   // chance the sender holds off a cycle
   int            recv_stall_pct = 0;  // chance the receiver stalls a cycle

   always #2 clock = ~clock;

   segment_segment_distance u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seg_a_x1   (req_seg_a_x1),
      .req_seg_a_y1   (req_seg_a_y1),
      .req_seg_a_x2   (req_seg_a_x2),
      .req_seg_a_y2   (req_seg_a_y2),
      .req_seg_b_x1   (req_seg_b_x1),
      .req_seg_b_y1   (req_seg_b_y1),
      .req_seg_b_x2   (req_seg_b_x2),
      .req_seg_b_y2   (req_seg_b_y2),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_distance   (rsp_distance),
      .rsp_intersects (rsp_intersects)
   );

   // Result side: check each accepted word, then pick next cycle's stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_gap(rsp_distance, rsp_intersects);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic seg_pair_type mk_pair(int ax1, int ay1, int ax2, int ay2,
                                            int bx1, int by1, int bx2, int by2);
      seg_pair_type s;
      s.ax1 = coord_type'(ax1); s.ay1 = coord_type'(ay1);
      s.ax2 = coord_type'(ax2); s.ay2 = coord_type'(ay2);
      s.bx1 = coord_type'(bx1); s.by1 = coord_type'(by1);
      s.bx2 = coord_type'(bx2); s.by2 = coord_type'(by2);
      return s;
   endfunction

   // Drive one word; idle first at random, hold until accepted
   task automatic send_pair(seg_pair_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_seg_a_x1 <= s.ax1; req_seg_a_y1 <= s.ay1;
      req_seg_a_x2 <= s.ax2; req_seg_a_y2 <= s.ay2;
      req_seg_b_x1 <= s.bx1; req_seg_b_y1 <= s.by1;
      req_seg_b_x2 <= s.bx2; req_seg_b_y2 <= s.by2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pair(s);
   endtask

   // Wait until every predicted result has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // Small coordinate in a window so that pairs often touch or cross
   function automatic int near(int span);
      return int'($urandom_range(2 * span)) - span;
   endfunction

   function automatic seg_pair_type rand_pair();
      seg_pair_type s;
      int           k, ox, oy, dx, dy, span;
      k = $urandom_range(9);
      span = ($urandom_range(3) == 0) ? 8 : 40000;
      ox = near(4000000);
      oy = near(4000000);
      case (k)
         0, 1: begin
            // full-range noise, every bit of every field
            s.ax1 = coord_type'($urandom); s.ay1 = coord_type'($urandom);
            s.ax2 = coord_type'($urandom); s.ay2 = coord_type'($urandom);
            s.bx1 = coord_type'($urandom); s.by1 = coord_type'($urandom);
            s.bx2 = coord_type'($urandom); s.by2 = coord_type'($urandom);
         end
         2, 3, 4: begin
            // clustered pair: crossing, near misses
            s = mk_pair(ox + near(span), oy + near(span), ox + near(span), oy + near(span),
                        ox + near(span), oy + near(span), ox + near(span), oy + near(span));
         end
         5: begin
            // collinear: all four points on one line through the origin point
            dx = near(300); dy = near(300);
            s = mk_pair(ox, oy, ox + near(6) * dx, oy,
                        ox, oy, ox, oy);
            k = near(6);
            s.ay2 = coord_type'(oy + (int'(s.ax2) - ox) / (dx == 0 ? 1 : dx) * dy);
            s.ax2 = coord_type'(ox + k * dx); s.ay2 = coord_type'(oy + k * dy);
            k = near(6);
            s.bx1 = coord_type'(ox + k * dx); s.by1 = coord_type'(oy + k * dy);
            k = near(6);
            s.bx2 = coord_type'(ox + k * dx); s.by2 = coord_type'(oy + k * dy);
         end
         6: begin
            // zero-length segment(s)
            s = mk_pair(ox, oy, ox, oy, ox + near(span), oy + near(span),
                        ox + near(span), oy + near(span));
            if ($urandom_range(1)) begin
               s.bx2 = s.bx1; s.by2 = s.by1;
            end
         end
         7: begin
            // shared endpoint
            s = mk_pair(ox, oy, ox + near(span), oy + near(span),
                        ox, oy, ox + near(span), oy + near(span));
            if ($urandom_range(1)) begin
               s.bx1 = s.ax2; s.by1 = s.ay2;
            end
         end
         8: begin
            // endpoint on the midpoint of the other segment (T junction)
            dx = near(span); dy = near(span);
            s = mk_pair(ox - dx, oy - dy, ox + dx, oy + dy, ox, oy,
                        ox + near(span), oy + near(span));
         end
         default: begin
            // extremes mixed with the window
            s = mk_pair(ox + near(span), oy + near(span), ox + near(span), oy + near(span),
                        ox + near(span), oy + near(span), ox + near(span), oy + near(span));
            if ($urandom_range(1)) s.ax1 = coord_type'({1'b1, {(CW - 1){1'b0}}});
            if ($urandom_range(1)) s.by2 = coord_type'({1'b0, {(CW - 1){1'b1}}});
         end
      endcase
      return s;
   endfunction

   localparam int MX = 8388607;
   localparam int MN = -8388608;
   localparam int ONE = 4096;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: extremes and each named special case
      send_pair(mk_pair(MX, MX, MX, MX, MX, MX, MX, MX));
      send_pair(mk_pair(MN, MN, MN, MN, MN, MN, MN, MN));
      send_pair(mk_pair(MN, MN, MN, MX, MX, MN, MX, MX));        // widest gap
      send_pair(mk_pair(MN, MN, MX, MX, MN, MX, MX, MN));        // full diagonals cross
      send_pair(mk_pair(MN, MN, MN, MN, MX, MX, MX, MX));        // two far points
      send_pair(mk_pair(0, 0, 4 * ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE));  // cross
      send_pair(mk_pair(0, 0, ONE, 0, ONE, 0, 2 * ONE, ONE));    // touch at endpoint
      send_pair(mk_pair(0, 0, 2 * ONE, 0, ONE, 0, ONE, ONE));    // T junction
      send_pair(mk_pair(0, 0, 2 * ONE, 0, ONE, 0, 3 * ONE, 0));  // collinear overlap
      send_pair(mk_pair(0, 0, ONE, 0, 2 * ONE, 0, 3 * ONE, 0));  // collinear apart
      send_pair(mk_pair(0, 0, ONE, 0, ONE, 0, 2 * ONE, 0));      // collinear touching
      send_pair(mk_pair(0, 0, 2 * ONE, 0, 0, ONE, 2 * ONE, ONE)); // parallel
      send_pair(mk_pair(5, 7, 5, 7, 5, 7, 5, 7));                 // two equal points
      send_pair(mk_pair(5, 7, 5, 7, 9, 10, 9, 10));               // two points apart
      send_pair(mk_pair(ONE, 0, ONE, 0, 0, 0, 2 * ONE, 0));       // point on segment
      send_pair(mk_pair(ONE, ONE, ONE, ONE, 0, 0, 2 * ONE, 0));   // point off segment
      send_pair(mk_pair(0, 0, 3, 1, 5, 0, 9, 1));                 // skewed near miss
      send_pair(mk_pair(0, 0, 10, 0, 12, 3, 20, 9));              // endpoint nearest
      send_pair(mk_pair(-1, -1, 1, 1, -1, 1, 1, -1));             // tiny cross
      send_pair(mk_pair(0, 0, 1, 0, 0, 1, 1, 1));                 // one-lsb gap
      drain();

      // Random words in three idling phases; pause for a full drain between
      send_idle_pct = 32; recv_stall_pct = 67;
      repeat (280) send_pair(rand_pair());
      drain();
      send_idle_pct = 67; recv_stall_pct = 32;
      repeat (280) send_pair(rand_pair());
      drain();
      send_idle_pct = 0; recv_stall_pct = 0;
      repeat (290) send_pair(rand_pair());
      drain();

      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("segment_segment_distance test passed");
      end else begin
         $display("segment_segment_distance test failed");
      end
      $finish;
   end

   // Watchdog: hung handshake or lost result
   initial begin
      #2000000;
      $display("segment_segment_distance test failed");
      $finish;
   end

endmodule

>>> segment_segment_distance.f
+incdir+rtl
rtl/ssd_pkg.sv
rtl/segment_segment_distance.sv
tb/testbench.sv
